>>> rtl/kmp_pkg.sv
// Shared types and codes for the KMP substring matcher.
package kmp_pkg;

  // Item kinds decided at the front
  localparam logic KIND_PATTERN = 1'b0;
  localparam logic KIND_TEXT    = 1'b1;

  // One classified request as it waits in the queue
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } kmp_item_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic      valid;
    kmp_item_t item;
  } kmp_head_t;

  // One search result
  typedef struct packed {
    logic match_here;
    logic found;
    logic text_done;
  } kmp_result_t;

endpackage

>>> rtl/kmp_in_if.sv
// Input channel: pattern and text bytes with valid/ready handshake.
interface kmp_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;
  logic       end_marker;

  modport source (output valid, output op, output data_byte, output end_marker,
                  input ready);
  modport sink   (input valid, input op, input data_byte, input end_marker,
                  output ready);
endinterface

>>> rtl/kmp_out_if.sv
// Output channel: one search result per text byte with valid/ready handshake.
interface kmp_out_if;
  logic valid;
  logic ready;
  logic match_here;
  logic found;
  logic text_done;

  modport source (output valid, output match_here, output found, output text_done,
                  input ready);
  modport sink   (input valid, input match_here, input found, input text_done,
                  output ready);
endinterface

>>> rtl/kmp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, held while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/kmp_front.sv
// Front end: accept requests, classify them and hold them in a two-entry queue.
module kmp_front (
  input  logic              clk,
  input  logic              rst,
  kmp_in_if.sink            req,
  output kmp_pkg::kmp_head_t head,
  input  logic              pop
);
  import kmp_pkg::*;

  kmp_item_t  entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  kmp_item_t  item_in;

  // Classify the incoming request
  always_comb begin
    item_in.kind = req.op ? KIND_TEXT : KIND_PATTERN;
    item_in.data = req.data_byte;
    item_in.last = req.end_marker;
  end

  assign req.ready  = (count != 2'd2);
  assign push       = req.valid && req.ready;
  assign head.valid = (count != 2'd0);
  assign head.item  = entry[rd_ptr];

  // Store accepted requests
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= item_in;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/kmp_engine.sv
// Back end: pattern store, failure table, KMP sequencer and result register.
module kmp_engine #(
  parameter int MAX_PATTERN = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  kmp_pkg::kmp_head_t head,
  output logic              pop,
  kmp_out_if.source         rsp
);
  import kmp_pkg::*;

  localparam int IW = $clog2(MAX_PATTERN);
  localparam int LW = $clog2(MAX_PATTERN + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_FAIL = 2'd2;
  localparam logic [1:0] S_HIT  = 2'd3;

  // Control and search state
  logic [1:0]    state, state_next;
  logic [LW-1:0] pat_len, pat_len_next;
  logic          pat_closed, pat_closed_next;
  logic [IW-1:0] pre_k, pre_k_next;
  logic [IW-1:0] match_cnt, match_cnt_next;
  logic          found_flag, found_flag_next;
  logic          out_valid, out_valid_next;
  kmp_result_t   out_res, out_res_next;

  // Working registers for the item in progress
  logic          cur_kind, cur_kind_next;
  logic [7:0]    cur_data, cur_data_next;
  logic          cur_last, cur_last_next;
  logic [IW-1:0] cur_i, cur_i_next;
  logic [IW-1:0] k, k_next;

  // Memory ports
  logic          ps_we, ps_re;
  logic [IW-1:0] ps_waddr, ps_raddr;
  logic [7:0]    ps_wdata, ps_rdata;
  logic          fl_we, fl_re;
  logic [IW-1:0] fl_waddr, fl_raddr;
  logic [IW-1:0] fl_wdata, fl_rdata;

  logic          can_emit;
  logic          eq;
  logic [LW-1:0] k_inc;

  kmp_ram #(.WIDTH(8), .DEPTH(MAX_PATTERN)) u_pattern_ram (
    .clk(clk), .we(ps_we), .waddr(ps_waddr), .wdata(ps_wdata),
    .re(ps_re), .raddr(ps_raddr), .rdata(ps_rdata)
  );

  kmp_ram #(.WIDTH(IW), .DEPTH(MAX_PATTERN)) u_failure_ram (
    .clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
    .re(fl_re), .raddr(fl_raddr), .rdata(fl_rdata)
  );

  assign can_emit = !out_valid || rsp.ready;
  assign eq       = (ps_rdata == cur_data);
  assign k_inc    = LW'(k) + LW'(1);

  assign rsp.valid      = out_valid;
  assign rsp.match_here = out_res.match_here;
  assign rsp.found      = out_res.found;
  assign rsp.text_done  = out_res.text_done;

  // Sequencer
  always_comb begin
    logic          emit;
    logic          e_hit;
    logic          e_last;
    logic [IW-1:0] e_j;
    logic [LW-1:0] eff_len;
    logic [IW-1:0] start;

    emit    = 1'b0;
    e_hit   = 1'b0;
    e_last  = cur_last;
    e_j     = '0;
    eff_len = pat_closed ? '0 : pat_len;
    start   = '0;

    state_next      = state;
    pat_len_next    = pat_len;
    pat_closed_next = pat_closed;
    pre_k_next      = pre_k;
    match_cnt_next  = match_cnt;
    found_flag_next = found_flag;
    cur_kind_next   = cur_kind;
    cur_data_next   = cur_data;
    cur_last_next   = cur_last;
    cur_i_next      = cur_i;
    k_next          = k;
    pop             = 1'b0;

    ps_we    = 1'b0;
    ps_waddr = eff_len[IW-1:0];
    ps_wdata = head.item.data;
    ps_re    = 1'b0;
    ps_raddr = '0;
    fl_we    = 1'b0;
    fl_waddr = cur_i;
    fl_wdata = '0;
    fl_re    = 1'b0;
    fl_raddr = '0;

    unique case (state)
      S_IDLE: begin
        if (head.valid && head.item.kind == KIND_PATTERN) begin
          pop = 1'b1;
          // A pattern byte after a closed pattern starts a new one
          if (pat_closed) begin
            pat_len_next    = '0;
            pat_closed_next = 1'b0;
            pre_k_next      = '0;
            match_cnt_next  = '0;
            found_flag_next = 1'b0;
          end
          if (eff_len < LW'(MAX_PATTERN)) begin
            ps_we = 1'b1;
            if (eff_len == '0) begin
              fl_we           = 1'b1;
              fl_waddr        = '0;
              fl_wdata        = '0;
              pre_k_next      = '0;
              pat_len_next    = LW'(1);
              pat_closed_next = head.item.last;
            end else begin
              start         = (LW'(pre_k) >= eff_len) ? '0 : pre_k;
              ps_re         = 1'b1;
              ps_raddr      = start;
              k_next        = start;
              cur_kind_next = KIND_PATTERN;
              cur_data_next = head.item.data;
              cur_last_next = head.item.last;
              cur_i_next    = eff_len[IW-1:0];
              state_next    = S_CMP;
            end
          end else if (head.item.last) begin
            // Drop the byte, but let its end marker close the pattern
            pat_closed_next = 1'b1;
          end
        end else if (head.valid) begin
          if (pat_len == '0) begin
            // Empty pattern matches everywhere
            if (can_emit) begin
              pop    = 1'b1;
              emit   = 1'b1;
              e_hit  = 1'b1;
              e_last = head.item.last;
              e_j    = match_cnt;
            end
          end else begin
            pop           = 1'b1;
            start         = (LW'(match_cnt) >= pat_len) ? '0 : match_cnt;
            ps_re         = 1'b1;
            ps_raddr      = start;
            k_next        = start;
            cur_kind_next = KIND_TEXT;
            cur_data_next = head.item.data;
            cur_last_next = head.item.last;
            state_next    = S_CMP;
          end
        end
      end

      S_CMP: begin
        if (eq && cur_kind == KIND_PATTERN) begin
          fl_we           = 1'b1;
          fl_wdata        = k_inc[IW-1:0];
          pre_k_next      = k_inc[IW-1:0];
          pat_len_next    = LW'(cur_i) + LW'(1);
          pat_closed_next = cur_last;
          state_next      = S_IDLE;
        end else if (eq) begin
          if (k_inc == pat_len) begin
            // Full match: fetch the fallback count
            fl_re      = 1'b1;
            fl_raddr   = IW'(pat_len - LW'(1));
            state_next = S_HIT;
          end else if (can_emit) begin
            emit       = 1'b1;
            e_j        = k_inc[IW-1:0];
            state_next = S_IDLE;
          end
        end else if (k != '0) begin
          // Follow the failure link
          fl_re      = 1'b1;
          fl_raddr   = k - IW'(1);
          state_next = S_FAIL;
        end else if (cur_kind == KIND_PATTERN) begin
          fl_we           = 1'b1;
          fl_wdata        = '0;
          pre_k_next      = '0;
          pat_len_next    = LW'(cur_i) + LW'(1);
          pat_closed_next = cur_last;
          state_next      = S_IDLE;
        end else if (can_emit) begin
          emit       = 1'b1;
          e_j        = '0;
          state_next = S_IDLE;
        end
      end

      S_FAIL: begin
        k_next     = fl_rdata;
        ps_re      = 1'b1;
        ps_raddr   = fl_rdata;
        state_next = S_CMP;
      end

      S_HIT: begin
        if (can_emit) begin
          emit       = 1'b1;
          e_hit      = 1'b1;
          e_j        = fl_rdata;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    // Load the result register, then clear the search at end of text
    out_valid_next = out_valid && !rsp.ready;
    out_res_next   = out_res;
    if (emit) begin
      out_valid_next          = 1'b1;
      out_res_next.match_here = e_hit;
      out_res_next.found      = found_flag || e_hit;
      out_res_next.text_done  = e_last;
      found_flag_next         = e_last ? 1'b0 : (found_flag || e_hit);
      match_cnt_next          = e_last ? '0 : e_j;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pat_len    <= '0;
      pat_closed <= 1'b0;
      pre_k      <= '0;
      match_cnt  <= '0;
      found_flag <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      pat_len    <= pat_len_next;
      pat_closed <= pat_closed_next;
      pre_k      <= pre_k_next;
      match_cnt  <= match_cnt_next;
      found_flag <= found_flag_next;
      out_valid  <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_res  <= out_res_next;
    cur_kind <= cur_kind_next;
    cur_data <= cur_data_next;
    cur_last <= cur_last_next;
    cur_i    <= cur_i_next;
    k        <= k_next;
  end

endmodule

>>> rtl/kmp_substring_matcher.sv
// Top level of the KMP substring matcher.
// Streams a pattern and then text through one request channel (op 0 = pattern
// byte, op 1 = text byte) and returns one result per text byte. A two-entry
// queue decouples request acceptance from the search sequencer, and a result
// register decouples the sequencer from the result channel. The sequencer
// reads the pattern RAM and the failure RAM through one registered read port
// each, alternating between them. The first pattern byte, a dropped pattern
// byte and a text byte against an empty pattern are handled straight from
// idle; any other byte takes a compare, then a failure-RAM read and a new
// compare per failure link followed, and a full match on a text byte adds a
// fallback read before its result. Pattern bytes past MAX_PATTERN are
// dropped, though their end marker still closes the pattern; no clearing
// pass is needed after reset.
module kmp_substring_matcher #(
  parameter int MAX_PATTERN = 32
) (
  input logic       clk,
  input logic       rst,
  kmp_in_if.sink    req,
  kmp_out_if.source rsp
);
  import kmp_pkg::*;

  kmp_head_t head;
  logic      pop;

  kmp_front u_front (
    .clk(clk), .rst(rst), .req(req), .head(head), .pop(pop)
  );

  kmp_engine #(.MAX_PATTERN(MAX_PATTERN)) u_engine (
    .clk(clk), .rst(rst), .head(head), .pop(pop), .rsp(rsp)
  );

endmodule

>>> rtl/kmp_checker.sv
// Port-level checker for the KMP substring matcher and its bind.
module kmp_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic req_op,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic rsp_match_here,
  input logic rsp_found,
  input logic rsp_text_done
);

  logic [2:0] pending;
  logic       text_acc;
  logic       rsp_acc;

  assign text_acc = req_valid && req_ready && req_op;
  assign rsp_acc  = rsp_valid && rsp_ready;

  // Count text requests still owed a result
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
    end else begin
      case ({text_acc, rsp_acc})
        2'b10:   pending <= pending + 3'd1;
        2'b01:   pending <= pending - 3'd1;
        default: pending <= pending;
      endcase
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      rsp_valid && $stable(rsp_match_here) && $stable(rsp_found) && $stable(rsp_text_done))
    else $error("result changed while stalled");

  a_match_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (!rsp_match_here || rsp_found))
    else $error("match reported without found");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 3'd0)
    else $error("result without a text request");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd4)
    else $error("more text requests in flight than storage allows");

endmodule

bind kmp_substring_matcher kmp_checker u_kmp_checker (
  .clk(clk),
  .rst(rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .req_op(req.op),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_match_here(rsp.match_here),
  .rsp_found(rsp.found),
  .rsp_text_done(rsp.text_done)
);
